// ===== design/http_request_head_parser_macros.svh =====
// Assertion macros shared by the parser modules.
// Expects signals named clk and arst_n in the module that uses them.
`ifndef HTTP_REQUEST_HEAD_PARSER_MACROS_SVH
`define HTTP_REQUEST_HEAD_PARSER_MACROS_SVH

// condition implies consequence in the same cycle
`define HRHP_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("hrhp: same-cycle check failed");

// condition implies consequence in the next cycle
`define HRHP_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("hrhp: next-cycle check failed");

`endif

// ===== design/hrhp_pkg.sv =====
// Shared types and constants of the HTTP request head parser.
// No dependencies; used by every module of the parser.
`timescale 1ns / 1ps

package hrhp_pkg;

	// result kinds
	typedef enum logic [2:0] {
		K_URI    = 3'd0,
		K_HEADER = 3'd1,
		K_LINE   = 3'd2,
		K_HEAD   = 3'd3,
		K_BODY   = 3'd4,
		K_BAD    = 3'd5
	} kind_t;

	// method codes
	typedef enum logic [2:0] {
		M_GET     = 3'd0,
		M_POST    = 3'd1,
		M_PUT     = 3'd2,
		M_HEAD    = 3'd3,
		M_DELETE  = 3'd4,
		M_OPTIONS = 3'd5,
		M_NONE    = 3'd6
	} method_t;

	// parse phases
	typedef enum logic [2:0] {
		PH_METHOD = 3'd0,
		PH_URI    = 3'd1,
		PH_TAIL   = 3'd2,
		PH_HEADER = 3'd3,
		PH_BODY   = 3'd4,
		PH_IGNORE = 3'd5
	} phase_t;

	// position within a line
	typedef enum logic [1:0] {
		LP_START = 2'd0,
		LP_ONE   = 2'd1,
		LP_MORE  = 2'd2
	} lpos_t;

	// percent-escape progress
	typedef enum logic [1:0] {
		ESC_NONE = 2'd0,
		ESC_PCT  = 2'd1,
		ESC_HIGH = 2'd2
	} esc_t;

	// characters the parser looks for
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_PCT   = 8'h25;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_0     = 8'h30;
	localparam logic [7:0] CH_UA    = 8'h41;
	localparam logic [7:0] CH_UZ    = 8'h5A;
	localparam logic [7:0] CH_LA    = 8'h61;
	localparam logic [7:0] CH_LZ    = 8'h7A;
	localparam logic [7:0] CH_D     = 8'h44;
	localparam logic [7:0] CH_G     = 8'h47;
	localparam logic [7:0] CH_H     = 8'h48;
	localparam logic [7:0] CH_O     = 8'h4F;
	localparam logic [7:0] CH_P     = 8'h50;
	localparam logic [7:0] HEX_GAP  = 8'd7;
	localparam logic [7:0] CASE_GAP = 8'd32;

	// queue between front and back
	localparam int QDepth = 4;
	localparam int QAw    = $clog2(QDepth);
	localparam int QCw    = $clog2(QDepth + 1);

	// input request
	typedef struct packed {
		logic [7:0] data_byte;
		logic       message_start;
	} req_t;

	// one result
	typedef struct packed {
		kind_t      kind;
		logic [7:0] value;
		method_t    method;
		logic       last_of_run;
	} res_t;

	// one emitted item without method
	typedef struct packed {
		kind_t      kind;
		logic [7:0] value;
	} item_t;

	// all results caused by one byte
	typedef struct packed {
		item_t   r0;
		item_t   r1;
		logic    two;
		method_t method;
	} bundle_t;

endpackage

// ===== design/hrhp_front.sv =====
// Front end: takes request bytes, runs the parse state and builds result bundles.
// Depends on hrhp_pkg.
`timescale 1ns / 1ps

module hrhp_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic             q_full,
	input  hrhp_pkg::req_t   request,
	output logic             full,
	output logic             q_push,
	output hrhp_pkg::bundle_t q_data
);
	import hrhp_pkg::*;

	typedef struct packed {
		phase_t     phase;
		method_t    method;
		lpos_t      lpos;
		logic       lower;
		esc_t       esc;
		logic [7:0] hi;
		logic       cr;
	} pst_t;

	typedef struct packed {
		pst_t       st;
		logic       emit;
		item_t      item;
	} step_t;

	localparam pst_t PST_RESET = '{phase: PH_METHOD, method: M_NONE, lpos: LP_START,
		lower: 1'b0, esc: ESC_NONE, hi: 8'd0, cr: 1'b0};

	// lenient hex digit value
	function automatic logic [7:0] hexv(input logic [7:0] c);
		logic [7:0] v;
		v = c - CH_0;
		if (c >= CH_UA) v = v - HEX_GAP;
		if (c >= CH_LA) v = v - CASE_GAP;
		return v;
	endfunction

	function automatic logic [7:0] upper(input logic [7:0] c);
		return (c >= CH_LA && c <= CH_LZ) ? c - CASE_GAP : c;
	endfunction

	// one content byte of a line
	function automatic step_t content(input pst_t s, input logic [7:0] c);
		step_t r;
		logic [7:0] v;
		r.st = s;
		r.emit = 1'b0;
		r.item = '{kind: K_URI, value: c};
		unique case (s.phase)
			PH_METHOD: begin
				if (s.lpos == LP_START) begin
					case (c)
						CH_P:    r.st.method = M_PUT;
						CH_G:    r.st.method = M_GET;
						CH_H:    r.st.method = M_HEAD;
						CH_D:    r.st.method = M_DELETE;
						CH_O:    r.st.method = M_OPTIONS;
						default: r.st.method = M_NONE;
					endcase
				end else if (s.lpos == LP_ONE && s.method == M_PUT && c == CH_O) begin
					r.st.method = M_POST;
				end
				if (c == CH_SPACE) r.st.phase = PH_URI;
			end
			PH_URI: begin
				if (s.lpos == LP_ONE && s.method == M_PUT && c == CH_O)
					r.st.method = M_POST;
				if (c == CH_SPACE) begin
					r.st.esc = ESC_NONE;
					r.st.phase = PH_TAIL;
				end else if (s.esc == ESC_NONE) begin
					if (c == CH_PCT) begin
						r.st.esc = ESC_PCT;
					end else begin
						r.emit = 1'b1;
						r.item.value = upper(c);
					end
				end else if (s.esc == ESC_PCT) begin
					r.st.hi = hexv(c);
					r.st.esc = ESC_HIGH;
				end else begin
					v = {s.hi[3:0], 4'b0000} | hexv(c);
					r.st.esc = ESC_NONE;
					r.emit = 1'b1;
					r.item.value = upper(v);
				end
			end
			PH_TAIL: begin
				if (s.lpos == LP_ONE && s.method == M_PUT && c == CH_O)
					r.st.method = M_POST;
			end
			default: begin
				// header line: lowercase the name of a line that opens uppercase
				v = c;
				if (s.lpos == LP_START && c >= CH_UA && c <= CH_UZ) r.st.lower = 1'b1;
				if (r.st.lower) begin
					if (c == CH_COLON) r.st.lower = 1'b0;
					else if (c >= CH_UA && c <= CH_UZ) v = c + CASE_GAP;
				end
				r.emit = 1'b1;
				r.item = '{kind: K_HEADER, value: v};
			end
		endcase
		if (s.lpos == LP_START) r.st.lpos = LP_ONE;
		else r.st.lpos = LP_MORE;
		return r;
	endfunction

	// CR LF seen
	function automatic step_t line_end(input pst_t s);
		step_t r;
		r.st = s;
		r.emit = 1'b1;
		r.item = '{kind: K_LINE, value: 8'd0};
		if (s.phase == PH_HEADER) begin
			if (s.lpos == LP_START) begin
				r.item.kind = K_HEAD;
				r.st.phase = (s.method == M_POST) ? PH_BODY : PH_IGNORE;
			end
		end else begin
			r.item.kind = (s.phase == PH_TAIL) ? K_LINE : K_BAD;
			r.st.phase = PH_HEADER;
		end
		r.st.lpos = LP_START;
		r.st.lower = 1'b0;
		r.st.esc = ESC_NONE;
		return r;
	endfunction

	pst_t  st_q, st_d, s0;
	step_t sa, sb;
	logic  take, lone;

	assign full = q_full;
	assign take = push && !q_full;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= PST_RESET;
		end else if (take) begin
			st_q <= st_d;
		end
	end

	// next state and bundle
	always_comb begin
		s0 = request.message_start ? PST_RESET : st_q;
		sa = '{st: s0, emit: 1'b0, item: '{kind: K_BODY, value: request.data_byte}};
		sb = sa;
		lone = 1'b0;
		if (s0.phase == PH_BODY) begin
			sa.emit = 1'b1;
		end else if (s0.phase == PH_IGNORE) begin
			sa.emit = 1'b0;
		end else if (s0.cr) begin
			s0.cr = 1'b0;
			if (request.data_byte == CH_LF) begin
				sa = line_end(s0);
			end else begin
				// lone CR is content, then this byte
				lone = 1'b1;
				sa = content(s0, CH_CR);
				sb = content(sa.st, request.data_byte);
			end
		end else if (request.data_byte == CH_CR) begin
			sa.st.cr = 1'b1;
		end else begin
			sa = content(s0, request.data_byte);
		end
		// the second step is only taken after a lone CR
		st_d = lone ? sb.st : sa.st;
		q_data.method = st_d.method;
		q_data.two = sa.emit && sb.emit;
		q_data.r0 = sa.emit ? sa.item : sb.item;
		q_data.r1 = sb.item;
		q_push = take && (sa.emit || sb.emit);
	end

endmodule

// ===== design/hrhp_fifo.sv =====
// Short bundle queue between front and back.
// Depends on hrhp_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "http_request_head_parser_macros.svh"

module hrhp_fifo (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              wr,
	input  hrhp_pkg::bundle_t wdata,
	input  logic              rd,
	output hrhp_pkg::bundle_t rdata,
	output logic              q_full,
	output logic              q_empty
);
	import hrhp_pkg::*;

	bundle_t          mem_q [QDepth];
	logic [QAw-1:0]   wp_q, rp_q;
	logic [QCw-1:0]   cnt_q;

	assign q_full  = (cnt_q == QCw'(QDepth));
	assign q_empty = (cnt_q == '0);
	assign rdata   = mem_q[rp_q];

	// storage
	always_ff @(posedge clk) begin
		if (wr) mem_q[wp_q] <= wdata;
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (wr) wp_q <= wp_q + 1'b1;
			if (rd) rp_q <= rp_q + 1'b1;
			if (wr && !rd) cnt_q <= cnt_q + 1'b1;
			else if (rd && !wr) cnt_q <= cnt_q - 1'b1;
		end
	end

	`HRHP_ASSERT_IMP(a_no_overflow, wr, !q_full || rd)
	`HRHP_ASSERT_IMP(a_no_underflow, rd, !q_empty)

endmodule

// ===== design/hrhp_back.sv =====
// Back end: unpacks bundles into single results behind an output register.
// Depends on hrhp_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "http_request_head_parser_macros.svh"

module hrhp_back (
	input  logic              clk,
	input  logic              arst_n,
	input  hrhp_pkg::bundle_t q_data,
	input  logic              q_empty,
	output logic              q_rd,
	input  logic              pop,
	output logic              empty,
	output hrhp_pkg::res_t    result
);
	import hrhp_pkg::*;

	bundle_t bun_q;
	logic    vld_q;
	logic    idx_q;
	logic    last, done;
	item_t   cur;

	assign last  = (idx_q == bun_q.two);
	assign done  = vld_q && pop && last;
	assign q_rd  = !q_empty && (!vld_q || done);
	assign empty = !vld_q;
	assign cur   = idx_q ? bun_q.r1 : bun_q.r0;
	assign result = '{kind: cur.kind, value: cur.value, method: bun_q.method,
		last_of_run: last};

	// bundle register
	always_ff @(posedge clk) begin
		if (q_rd) bun_q <= q_data;
	end

	// valid flag and result index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
			idx_q <= 1'b0;
		end else begin
			if (q_rd) begin
				vld_q <= 1'b1;
				idx_q <= 1'b0;
			end else if (done) begin
				vld_q <= 1'b0;
			end else if (vld_q && pop) begin
				idx_q <= 1'b1;
			end
		end
	end

	`HRHP_ASSERT_IMP(a_second_needs_two, vld_q && idx_q, bun_q.two)
	`HRHP_ASSERT_NXT(a_load_shows, q_rd, vld_q && !idx_q)

endmodule

// ===== design/http_request_head_parser.sv =====
// Top level of the HTTP request head parser.
// Depends on hrhp_pkg, hrhp_front, hrhp_fifo and hrhp_back.
`timescale 1ns / 1ps

// Takes one request byte per clock while full is low and delivers one result per
// clock while pop is high and empty is low. The front parses the byte in the cycle
// it is accepted and writes its results, if any, as a bundle of one or two into a
// four-entry queue; the back unpacks bundles into an output register, so the
// first result of a byte passes the queue and then the bundle register before it
// appears. A byte that causes two results (a lone carriage return followed by
// content) needs a pop for each at the result side; the queue absorbs these and
// the input stalls (full) only when four bundles wait in the queue behind the one
// in the output register. Sustained input rate is one byte per cycle whenever pop
// is held high and two-result bytes are rare enough for the queue to absorb.
module http_request_head_parser (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	output logic            full,
	input  hrhp_pkg::req_t  request,
	output logic            empty,
	input  logic            pop,
	output hrhp_pkg::res_t  result
);
	import hrhp_pkg::*;

	bundle_t wdata, rdata;
	logic    q_push, q_full, q_empty, q_rd;

	hrhp_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.q_full  (q_full),
		.request (request),
		.full    (full),
		.q_push  (q_push),
		.q_data  (wdata)
	);

	hrhp_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (q_push),
		.wdata   (wdata),
		.rd      (q_rd),
		.rdata   (rdata),
		.q_full  (q_full),
		.q_empty (q_empty)
	);

	hrhp_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_data  (rdata),
		.q_empty (q_empty),
		.q_rd    (q_rd),
		.pop     (pop),
		.empty   (empty),
		.result  (result)
	);

endmodule

// ===== tb/tb_http_request_head_parser.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for http_request_head_parser: directed and random HTTP request
// heads and bodies are pushed byte by byte, each result checked against a local parser.
// Depends on hrhp_pkg and the http_request_head_parser design.

module tb_http_request_head_parser;
	import hrhp_pkg::*;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic push = 1'b0;
	logic pop = 1'b0;
	logic full;
	logic empty;
	req_t request = '0;
	res_t result;

	// pending request bytes and predicted results
	req_t byte_q[$];
	res_t parsed_q[$];
	kind_t run_kind[$];
	logic [7:0] run_val[$];

	int item_cnt = 0;
	int accepted_cnt = 0;
	int mismatches = 0;
	int send_idle_pct = 6;
	int recv_idle_pct = 52;
	int stall_left = 0;
	bit stall_done = 1'b0;

	// local copy of the parse state
	phase_t ps;
	method_t mc;
	lpos_t lp;
	logic lowering;
	esc_t esc;
	logic [7:0] hi;
	logic cr_pend;

	http_request_head_parser u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.full    (full),
		.request (request),
		.empty   (empty),
		.pop     (pop),
		.result  (result)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// ---------------------------------------------------------------- parser
	function automatic void clear_parse();
		ps = PH_METHOD;
		mc = M_NONE;
		lp = LP_START;
		lowering = 1'b0;
		esc = ESC_NONE;
		hi = 8'h00;
		cr_pend = 1'b0;
	endfunction

	function automatic void emit(input kind_t k, input logic [7:0] v);
		run_kind.push_back(k);
		run_val.push_back(v);
	endfunction

	// lenient hex digit: no validity check, wraps mod 256
	function automatic logic [7:0] hex_nib(input logic [7:0] c);
		logic [7:0] v;
		v = c - CH_0;
		if (c >= CH_UA) v = v - HEX_GAP;
		if (c >= CH_LA) v = v - CASE_GAP;
		return v;
	endfunction

	function automatic logic [7:0] to_upper(input logic [7:0] c);
		if (c >= CH_LA && c <= CH_LZ) return c - CASE_GAP;
		return c;
	endfunction

	// second byte 'O' after 'P' turns PUT into POST
	function automatic void check_post(input logic [7:0] c);
		if (lp == LP_ONE && mc == M_PUT && c == CH_O) mc = M_POST;
	endfunction

	function automatic void line_content(input logic [7:0] c);
		logic [7:0] v;
		case (ps)
			PH_METHOD: begin
				if (lp == LP_START) begin
					case (c)
						CH_P: mc = M_PUT;
						CH_G: mc = M_GET;
						CH_H: mc = M_HEAD;
						CH_D: mc = M_DELETE;
						CH_O: mc = M_OPTIONS;
						default: mc = M_NONE;
					endcase
				end else begin
					check_post(c);
				end
				if (c == CH_SPACE) ps = PH_URI;
			end
			PH_URI: begin
				check_post(c);
				if (c == CH_SPACE) begin
					esc = ESC_NONE;
					ps = PH_TAIL;
				end else if (esc == ESC_NONE) begin
					if (c == CH_PCT) esc = ESC_PCT;
					else emit(K_URI, to_upper(c));
				end else if (esc == ESC_PCT) begin
					hi = hex_nib(c);
					esc = ESC_HIGH;
				end else begin
					v = {hi[3:0], 4'h0} | hex_nib(c);
					esc = ESC_NONE;
					emit(K_URI, to_upper(v));
				end
			end
			PH_TAIL: check_post(c);
			default: begin
				// header line: lowercase the name up to the colon when the line opens uppercase
				v = c;
				if (lp == LP_START && c >= CH_UA && c <= CH_UZ) lowering = 1'b1;
				if (lowering) begin
					if (c == CH_COLON) lowering = 1'b0;
					else if (c >= CH_UA && c <= CH_UZ) v = c + CASE_GAP;
				end
				emit(K_HEADER, v);
			end
		endcase
		if (lp == LP_START) lp = LP_ONE;
		else lp = LP_MORE;
	endfunction

	function automatic void line_end();
		if (ps == PH_HEADER) begin
			if (lp == LP_START) begin
				emit(K_HEAD, 8'h00);
				if (mc == M_POST) ps = PH_BODY;
				else ps = PH_IGNORE;
			end else begin
				emit(K_LINE, 8'h00);
			end
		end else begin
			// request line without its second space is flagged
			if (ps == PH_TAIL) emit(K_LINE, 8'h00);
			else emit(K_BAD, 8'h00);
			ps = PH_HEADER;
		end
		lp = LP_START;
		lowering = 1'b0;
		esc = ESC_NONE;
	endfunction

	// predict the results of one accepted request byte
	task automatic parse_byte(input req_t rq);
		logic [7:0] c;
		res_t r;
		int i;
		c = rq.data_byte;
		run_kind.delete();
		run_val.delete();
		if (rq.message_start) clear_parse();
		if (ps == PH_BODY) begin
			emit(K_BODY, c);
		end else if (ps == PH_IGNORE) begin
			// rest of a non-POST message
		end else if (cr_pend) begin
			cr_pend = 1'b0;
			if (c == CH_LF) begin
				line_end();
			end else begin
				// lone CR: both bytes are content
				line_content(CH_CR);
				line_content(c);
			end
		end else if (c == CH_CR) begin
			cr_pend = 1'b1;
		end else begin
			line_content(c);
		end
		for (i = 0; i < run_kind.size(); i++) begin
			r.kind = run_kind[i];
			r.value = run_val[i];
			r.method = mc;
			r.last_of_run = (i == run_kind.size() - 1);
			parsed_q.push_back(r);
		end
	endtask

	// ---------------------------------------------------------------- stimulus
	task automatic add_byte(input logic [7:0] c, input logic first);
		req_t r;
		r.data_byte = c;
		r.message_start = first;
		byte_q.push_back(r);
		item_cnt++;
	endtask

	task automatic add_text(input string s, input logic first);
		int i;
		for (i = 0; i < s.len(); i++) add_byte(s[i], first && i == 0);
	endtask

	task automatic add_crlf();
		add_byte(CH_CR, 1'b0);
		add_byte(CH_LF, 1'b0);
	endtask

	function automatic logic [7:0] pick(input string s);
		return s[$urandom_range(0, s.len() - 1)];
	endfunction

	task automatic add_random_bytes(input int n);
		int i;
		for (i = 0; i < n; i++) add_byte(8'($urandom_range(0, 255)), 1'b0);
	endtask

	// one request: mostly well formed, with occasional breakage
	task automatic gen_request();
		int i, n, sel, hdrs;
		string hexd, uri_chars, letters, val_chars;
		hexd = "0123456789abcdefABCDEF";
		uri_chars = "abcxyzABCXYZ09/.-~?=&";
		letters = "abzABZhostHOST";
		val_chars = "aZ09 :/.-Xq";
		case ($urandom_range(0, 7))
			0: add_text("GET", 1'b1);
			1: add_text("POST", 1'b1);
			2: add_text("PUT", 1'b1);
			3: add_text("HEAD", 1'b1);
			4: add_text("DELETE", 1'b1);
			5: add_text("OPTIONS", 1'b1);
			6: add_text("PATCH", 1'b1);
			default: begin
				add_byte(8'($urandom_range(0, 255)), 1'b1);
				add_text("X", 1'b0);
			end
		endcase
		// abandoned with a CR pending; the next message restarts parsing
		if ($urandom_range(0, 14) == 0) begin
			add_byte(CH_CR, 1'b0);
			return;
		end
		add_text(" ", 1'b0);
		n = $urandom_range(1, 5);
		for (i = 0; i < n; i++) begin
			sel = $urandom_range(0, 9);
			if (sel < 6) begin
				add_byte(pick(uri_chars), 1'b0);
			end else if (sel < 8) begin
				add_byte(CH_PCT, 1'b0);
				add_byte(pick(hexd), 1'b0);
				add_byte(pick(hexd), 1'b0);
			end else if (sel == 8) begin
				add_byte(CH_PCT, 1'b0);
				add_random_bytes(2);
			end else begin
				add_random_bytes(1);
			end
		end
		if ($urandom_range(0, 19) == 0) begin
			// escape pending when a new message starts
			add_byte(CH_PCT, 1'b0);
			add_byte(CH_CR, 1'b0);
			return;
		end
		if ($urandom_range(0, 9) == 0) begin
			// missing second space, maybe with a cut-short escape
			if ($urandom_range(0, 1)) add_text("%4", 1'b0);
			add_crlf();
		end else begin
			add_text(" HTTP/1.1", 1'b0);
			if ($urandom_range(0, 9) == 0) add_text("%", 1'b0);
			add_crlf();
		end
		hdrs = $urandom_range(0, 3);
		for (i = 0; i < hdrs; i++) begin
			if ($urandom_range(0, 4) != 0) add_byte(pick("ACHUZ"), 1'b0);
			else add_byte(pick("achz-"), 1'b0);
			n = $urandom_range(0, 4);
			repeat (n) add_byte(pick(letters), 1'b0);
			if ($urandom_range(0, 9) == 0) begin
				add_byte(CH_CR, 1'b0);
				add_byte(pick(letters), 1'b0);
			end
			add_text(":", 1'b0);
			n = $urandom_range(0, 4);
			repeat (n) add_byte(pick(val_chars), 1'b0);
			add_crlf();
		end
		add_crlf();
	endtask

	// request followed by a body (POST) or, now and then, a single ignored byte
	task automatic gen_message();
		int base_idx;
		bit is_post;
		base_idx = byte_q.size();
		gen_request();
		// the method text sits at the start of the bytes just added
		is_post = (byte_q.size() - base_idx >= 4) &&
			byte_q[base_idx].data_byte == CH_P && byte_q[base_idx + 1].data_byte == CH_O;
		if (is_post) add_random_bytes($urandom_range(0, 12));
		else if ($urandom_range(0, 9) == 0) add_random_bytes(1);
	endtask

	task automatic load_directed();
		// blank first line, then an empty head
		add_byte(CH_CR, 1'b1);
		add_byte(CH_LF, 1'b0);
		add_crlf();
		// new message while a CR is pending
		add_text("PO", 1'b1);
		add_byte(CH_CR, 1'b0);
		add_text("X ", 1'b1);
		// extreme bytes, escape split by a lone CR, raw LF in the uri
		add_byte(8'h00, 1'b0);
		add_byte(8'hFF, 1'b0);
		add_text("%4", 1'b0);
		add_byte(CH_CR, 1'b0);
		add_byte(CH_CR, 1'b0);
		add_byte(CH_LF, 1'b0);
		// escape cut short at the line end, no second space
		add_text("%4", 1'b0);
		add_crlf();
		add_text("Ab:C", 1'b0);
		add_crlf();
		add_crlf();
		add_byte(8'hFF, 1'b0);
	endtask

	// ---------------------------------------------------------------- driver
	always @(posedge clk) begin
		if (arst_n && push && !full) begin
			parse_byte(request);
			void'(byte_q.pop_front());
			accepted_cnt++;
		end
	end

	always @(negedge clk) begin
		if (byte_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
			push <= 1'b1;
			request <= byte_q[0];
		end else begin
			push <= 1'b0;
		end
	end

	// ---------------------------------------------------------------- monitor
	// one long hold-off lets the block fill up and assert full
	always @(negedge clk) begin
		if (stall_left > 0) begin
			stall_left--;
			pop <= 1'b0;
		end else if (!stall_done && accepted_cnt >= 120) begin
			stall_done = 1'b1;
			stall_left = 300;
			pop <= 1'b0;
		end else begin
			pop <= ($urandom_range(0, 99) >= recv_idle_pct);
		end
	end

	task automatic report_mismatch(input string what);
		mismatches++;
		if (mismatches <= 20) $display("MISMATCH: %s", what);
	endtask

	always @(posedge clk) begin
		res_t want;
		if (arst_n && pop && !empty) begin
			if (parsed_q.size() == 0) begin
				report_mismatch($sformatf("unexpected result kind=%0d value=%02h",
					result.kind, result.value));
			end else begin
				want = parsed_q.pop_front();
				if (result.kind !== want.kind || result.value !== want.value ||
					result.method !== want.method ||
					result.last_of_run !== want.last_of_run)
					report_mismatch($sformatf(
						"got kind=%0d value=%02h method=%0d last=%0b, want %0d %02h %0d %0b",
						result.kind, result.value, result.method, result.last_of_run,
						want.kind, want.value, want.method, want.last_of_run));
			end
		end
	end

	// ---------------------------------------------------------------- sequence
	initial begin
		int ph, target;
		clear_parse();
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		for (ph = 0; ph < 3; ph++) begin
			case (ph)
				0: begin send_idle_pct = 6; recv_idle_pct = 52; end
				1: begin send_idle_pct = 52; recv_idle_pct = 6; end
				default: begin send_idle_pct = 0; recv_idle_pct = 0; end
			endcase
			if (ph == 0) load_directed();
			target = item_cnt + 383;
			while (item_cnt < target) gen_message();
			// sender waits for every result before the next phase
			while (byte_q.size() != 0 || parsed_q.size() != 0) @(posedge clk);
		end
		repeat (20) @(posedge clk);
		if (mismatches == 0 && parsed_q.size() == 0) begin
			$display("tb_http_request_head_parser OK");
		end else begin
			$display("tb_http_request_head_parser NOT OK");
		end
		$finish;
	end

	initial begin
		#2000000;
		$display("tb_http_request_head_parser NOT OK");
		$finish;
	end

endmodule
